// ===== rtl/tbwv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbwv_pkg
// Types and constants shared by the touch button window vote block.
// ----------------------------------------------------------------------------
package tbwv_pkg;

  localparam int ZONE_COUNT = 4;
  localparam int COORD_W    = 12;
  localparam int HIT_W      = 8;
  localparam int WIN_W      = 8;

  // zone spans are open intervals (base+NEAR, base+FAR)
  localparam logic [COORD_W:0] ZONE_NEAR = 13'd30;
  localparam logic [COORD_W:0] ZONE_FAR  = 13'd70;

  localparam logic [2:0] NO_BUTTON = 3'd4;
  localparam logic [3:0] ALL_LEDS  = 4'hF;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_LEFT_X   = 3'd0;
  localparam logic [2:0] REG_RIGHT_X  = 3'd1;
  localparam logic [2:0] REG_TOP_Y    = 3'd2;
  localparam logic [2:0] REG_BOTTOM_Y = 3'd3;
  localparam logic [2:0] REG_WINDOW   = 3'd4;

  localparam logic [COORD_W-1:0] LEFT_X_RST   = 12'd20;
  localparam logic [COORD_W-1:0] RIGHT_X_RST  = 12'd120;
  localparam logic [COORD_W-1:0] TOP_Y_RST    = 12'd10;
  localparam logic [COORD_W-1:0] BOTTOM_Y_RST = 12'd100;
  localparam logic [WIN_W-1:0]   WINDOW_RST   = 8'd20;

  typedef struct packed {
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] button;
    logic [3:0] led_mask;
  } out_beat_t;

endpackage : tbwv_pkg
`default_nettype wire

// ===== rtl/touch_button_window_vote.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Takes one touch sample per cycle when not stalled and, after every
// window_length samples, delivers one beat with the zone that collected
// the most hits (lower zone wins ties, 4 when nothing was hit) and its LED
// mask. An accepted sample waits in the input register, then classification,
// hit count update, window check and vote are done in a single pass into
// the output register: out_valid rises as the last sample of a window moves
// on; one sample can be taken every cycle while the output side keeps up.
// in_stall rises only when out_stall holds a finished beat and a sample waits.
// ----------------------------------------------------------------------------
// touch_button_window_vote
// Four-zone touch button classifier with windowed majority vote and
// an APB-style register port for zone placement and window length.
// ----------------------------------------------------------------------------
module touch_button_window_vote (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // sample input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tbwv_pkg::in_beat_t in_data,
  // vote output
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tbwv_pkg::out_beat_t     out_data,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import tbwv_pkg::*;

  // configuration
  logic [COORD_W-1:0] left_x_r, right_x_r, top_y_r, bottom_y_r;
  logic [WIN_W-1:0]   window_r;

  // input register
  logic     s1_valid_r;
  in_beat_t s1_data_r;

  // vote state
  logic [HIT_W-1:0] hits_r   [ZONE_COUNT];
  logic [HIT_W-1:0] hits_nxt [ZONE_COUNT];
  logic [WIN_W-1:0] sample_cnt_r, sample_cnt_nxt;

  // output register
  logic      out_valid_r;
  out_beat_t out_data_r;

  logic [2:0] reg_idx;
  logic       cfg_wr;
  logic       advance;
  logic       in_take;
  logic       decide;

  logic [1:0]            col_hit, row_hit;
  logic [ZONE_COUNT-1:0] zone_hit;
  logic [ZONE_COUNT-1:0] zone_first;
  logic [1:0]            best;
  out_beat_t             vote;

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      REG_LEFT_X:   prdata = {20'd0, left_x_r};
      REG_RIGHT_X:  prdata = {20'd0, right_x_r};
      REG_TOP_Y:    prdata = {20'd0, top_y_r};
      REG_BOTTOM_Y: prdata = {20'd0, bottom_y_r};
      REG_WINDOW:   prdata = {24'd0, window_r};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_x_r   <= LEFT_X_RST;
      right_x_r  <= RIGHT_X_RST;
      top_y_r    <= TOP_Y_RST;
      bottom_y_r <= BOTTOM_Y_RST;
      window_r   <= WINDOW_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LEFT_X:   left_x_r   <= pwdata[COORD_W-1:0];
        REG_RIGHT_X:  right_x_r  <= pwdata[COORD_W-1:0];
        REG_TOP_Y:    top_y_r    <= pwdata[COORD_W-1:0];
        REG_BOTTOM_Y: bottom_y_r <= pwdata[COORD_W-1:0];
        REG_WINDOW:   window_r   <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  // the sample in s1 moves on whenever the output register is free this cycle
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // classify, count, vote
  // --------------------------------------------------------------------------
  // bounds are 13 bits wide so a zone near the top edge does not wrap
  always_comb begin
    col_hit[0] = ({1'b0, s1_data_r.x_pos} > ({1'b0, left_x_r} + ZONE_NEAR)) &&
                 ({1'b0, s1_data_r.x_pos} < ({1'b0, left_x_r} + ZONE_FAR));
    col_hit[1] = ({1'b0, s1_data_r.x_pos} > ({1'b0, right_x_r} + ZONE_NEAR)) &&
                 ({1'b0, s1_data_r.x_pos} < ({1'b0, right_x_r} + ZONE_FAR));
    row_hit[0] = ({1'b0, s1_data_r.y_pos} > ({1'b0, top_y_r} + ZONE_NEAR)) &&
                 ({1'b0, s1_data_r.y_pos} < ({1'b0, top_y_r} + ZONE_FAR));
    row_hit[1] = ({1'b0, s1_data_r.y_pos} > ({1'b0, bottom_y_r} + ZONE_NEAR)) &&
                 ({1'b0, s1_data_r.y_pos} < ({1'b0, bottom_y_r} + ZONE_FAR));
    for (int k = 0; k < ZONE_COUNT; k++) begin
      zone_hit[k] = col_hit[k % 2] && row_hit[k / 2];
    end
    // only the lowest zone hit counts
    zone_first = zone_hit & (~zone_hit + 4'd1);
  end

  always_comb begin
    sample_cnt_nxt = sample_cnt_r + 8'd1;
    decide         = (sample_cnt_nxt == window_r);
    for (int k = 0; k < ZONE_COUNT; k++) begin
      // saturate at full scale
      if (zone_first[k] && (hits_r[k] != {HIT_W{1'b1}})) begin
        hits_nxt[k] = hits_r[k] + 8'd1;
      end else begin
        hits_nxt[k] = hits_r[k];
      end
    end
    best = 2'd0;
    for (int k = 1; k < ZONE_COUNT; k++) begin
      if (hits_nxt[best] < hits_nxt[k]) begin
        best = 2'(k);
      end
    end
    if (hits_nxt[best] == '0) begin
      vote.button   = NO_BUTTON;
      vote.led_mask = ALL_LEDS;
    end else begin
      vote.button   = {1'b0, best};
      vote.led_mask = 4'b0001 << best;
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      sample_cnt_r <= '0;
      for (int k = 0; k < ZONE_COUNT; k++) begin
        hits_r[k] <= '0;
      end
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r <= decide;
        if (decide) begin
          sample_cnt_r <= '0;
          for (int k = 0; k < ZONE_COUNT; k++) begin
            hits_r[k] <= '0;
          end
        end else begin
          sample_cnt_r <= sample_cnt_nxt;
          for (int k = 0; k < ZONE_COUNT; k++) begin
            hits_r[k] <= hits_nxt[k];
          end
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (advance && decide) begin
      out_data_r <= vote;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_led_matches_button: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((out_data_r.button == NO_BUTTON) && (out_data_r.led_mask == ALL_LEDS)) ||
      ((out_data_r.button < NO_BUTTON) &&
       (out_data_r.led_mask == (4'b0001 << out_data_r.button[1:0]))))
    else $error("led mask does not match button");

  a_clear_after_vote: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && decide) |=> (sample_cnt_r == '0) && (hits_r[0] == '0) &&
      (hits_r[1] == '0) && (hits_r[2] == '0) && (hits_r[3] == '0))
    else $error("counts not cleared after a vote");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with a free output slot");

  a_result_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && decide))
    else $error("result appeared without a processed sample");

endmodule : touch_button_window_vote
`default_nettype wire
